### src/hsv2rgb_pkg.sv
// Package for the HSV to RGB converter: word types, clamp limits and
// the constants of the fixed-point scaling. No dependencies.
package hsv2rgb_pkg;

    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] saturation;
        logic [6:0] brightness;
    } t_hsv_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_word;

    typedef struct packed {
        logic en_prod;
        logic en_quot;
    } t_scale_ctrl;

    localparam logic [8:0]  HUE_MAX   = 9'd359;
    localparam logic [6:0]  PCT_MAX   = 7'd100;
    localparam logic [5:0]  SECTOR_DEG = 6'd60;
    localparam logic [12:0] W_FULL    = 13'd6000;

    // Division by 40000 as a multiplication by ceil(2^40 / 40000).
    localparam int          RECIP_SHIFT = 40;
    localparam logic [24:0] RECIP_M     = 25'd27487791;

    localparam logic [2:0] SECTOR_0 = 3'd0;
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;

endpackage

### src/hsv2rgb_scale.sv
// Two-stage channel scaler: floor(255 * v * w / 600000) for one weight.
// Depends on hsv2rgb_pkg.
module hsv2rgb_scale (
    input  logic                      i_clk,
    input  hsv2rgb_pkg::t_scale_ctrl  i_ctrl,
    input  logic [6:0]                i_v,
    input  logic [12:0]               i_w,
    output logic [7:0]                o_q
);

    logic [19:0] prod_vw;
    logic [23:0] n_x;
    logic [23:0] r_x;
    logic [48:0] prod_m;
    logic [7:0]  n_q;
    logic [7:0]  r_q;

    // 255 / 600000 reduces to 17 / 40000.
    assign prod_vw = 20'(i_v) * 20'(i_w);
    assign n_x     = {prod_vw, 4'b0} + {4'b0, prod_vw};
    assign prod_m  = 49'(r_x) * 49'(hsv2rgb_pkg::RECIP_M);
    assign n_q     = prod_m[hsv2rgb_pkg::RECIP_SHIFT +: 8];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_prod) begin
            r_x <= n_x;
        end
        if (i_ctrl.en_quot) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

### src/hsv_to_rgb_converter.sv
// HSV to RGB converter, five register stages.
// Throughput: one word per cycle while i_stall is low; each stage holds only
// while its successor is full and stalled, so bubbles close up.
// Reset clears the valid bit of every stage; data registers are not reset.
module hsv_to_rgb_converter (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  hsv2rgb_pkg::t_hsv_word  i_word,
    output logic                    o_valid,
    input  logic                    i_stall,
    output hsv2rgb_pkg::t_rgb_word  o_word
);

    logic [4:0] r_vld;
    logic [4:0] en;

    logic [8:0] hue_c;
    logic [6:0] sat_c;
    logic [6:0] val_c;
    logic [2:0] n_sector;
    logic [5:0] n_frac;

    logic [2:0] r1_sector;
    logic [5:0] r1_frac;
    logic [6:0] r1_sat;
    logic [6:0] r1_val;

    logic [5:0]  frac_rise;
    logic [12:0] prod_low;
    logic [12:0] prod_fall;
    logic [12:0] prod_rise;

    logic [2:0]  r2_sector;
    logic [6:0]  r2_val;
    logic [12:0] r2_w_low;
    logic [12:0] r2_w_fall;
    logic [12:0] r2_w_rise;

    logic [2:0] r3_sector;
    logic [2:0] r4_sector;

    hsv2rgb_pkg::t_scale_ctrl scale_ctrl;
    logic [7:0] q_full;
    logic [7:0] q_low;
    logic [7:0] q_fall;
    logic [7:0] q_rise;

    hsv2rgb_pkg::t_rgb_word n_out;
    hsv2rgb_pkg::t_rgb_word r_out;

    assign en[4] = !r_vld[4] || !i_stall;
    assign en[3] = !r_vld[3] || en[4];
    assign en[2] = !r_vld[2] || en[3];
    assign en[1] = !r_vld[1] || en[2];
    assign en[0] = !r_vld[0] || en[1];
    assign o_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            if (en[1]) r_vld[1] <= r_vld[0];
            if (en[2]) r_vld[2] <= r_vld[1];
            if (en[3]) r_vld[3] <= r_vld[2];
            if (en[4]) r_vld[4] <= r_vld[3];
        end
    end

    // Stage one: clamp the inputs and split the hue into sector and offset.
    assign hue_c = (i_word.hue > hsv2rgb_pkg::HUE_MAX) ? hsv2rgb_pkg::HUE_MAX : i_word.hue;
    assign sat_c = (i_word.saturation > hsv2rgb_pkg::PCT_MAX) ?
                   hsv2rgb_pkg::PCT_MAX : i_word.saturation;
    assign val_c = (i_word.brightness > hsv2rgb_pkg::PCT_MAX) ?
                   hsv2rgb_pkg::PCT_MAX : i_word.brightness;

    always_comb begin
        logic [8:0] rem;
        if (hue_c >= 9'd300) begin
            n_sector = hsv2rgb_pkg::SECTOR_5;
            rem      = hue_c - 9'd300;
        end else if (hue_c >= 9'd240) begin
            n_sector = hsv2rgb_pkg::SECTOR_4;
            rem      = hue_c - 9'd240;
        end else if (hue_c >= 9'd180) begin
            n_sector = hsv2rgb_pkg::SECTOR_3;
            rem      = hue_c - 9'd180;
        end else if (hue_c >= 9'd120) begin
            n_sector = hsv2rgb_pkg::SECTOR_2;
            rem      = hue_c - 9'd120;
        end else if (hue_c >= 9'd60) begin
            n_sector = hsv2rgb_pkg::SECTOR_1;
            rem      = hue_c - 9'd60;
        end else begin
            n_sector = hsv2rgb_pkg::SECTOR_0;
            rem      = hue_c;
        end
        n_frac = rem[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_sector <= n_sector;
            r1_frac   <= n_frac;
            r1_sat    <= sat_c;
            r1_val    <= val_c;
        end
    end

    // Stage two: channel weights 6000 - s * k.
    assign frac_rise = hsv2rgb_pkg::SECTOR_DEG - r1_frac;
    assign prod_low  = 13'(r1_sat) * 13'(hsv2rgb_pkg::SECTOR_DEG);
    assign prod_fall = 13'(r1_sat) * 13'(r1_frac);
    assign prod_rise = 13'(r1_sat) * 13'(frac_rise);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_sector <= r1_sector;
            r2_val    <= r1_val;
            r2_w_low  <= hsv2rgb_pkg::W_FULL - prod_low;
            r2_w_fall <= hsv2rgb_pkg::W_FULL - prod_fall;
            r2_w_rise <= hsv2rgb_pkg::W_FULL - prod_rise;
        end
    end

    // Stages three and four: scaling in the lane units.
    assign scale_ctrl.en_prod = en[2];
    assign scale_ctrl.en_quot = en[3];

    always_ff @(posedge i_clk) begin
        if (en[2]) r3_sector <= r2_sector;
        if (en[3]) r4_sector <= r3_sector;
    end

    hsv2rgb_scale u_scale_full (
        .i_clk  (i_clk),
        .i_ctrl (scale_ctrl),
        .i_v    (r2_val),
        .i_w    (hsv2rgb_pkg::W_FULL),
        .o_q    (q_full)
    );

    hsv2rgb_scale u_scale_low (
        .i_clk  (i_clk),
        .i_ctrl (scale_ctrl),
        .i_v    (r2_val),
        .i_w    (r2_w_low),
        .o_q    (q_low)
    );

    hsv2rgb_scale u_scale_fall (
        .i_clk  (i_clk),
        .i_ctrl (scale_ctrl),
        .i_v    (r2_val),
        .i_w    (r2_w_fall),
        .o_q    (q_fall)
    );

    hsv2rgb_scale u_scale_rise (
        .i_clk  (i_clk),
        .i_ctrl (scale_ctrl),
        .i_v    (r2_val),
        .i_w    (r2_w_rise),
        .o_q    (q_rise)
    );

    // Stage five: route the four levels to the channels by sector.
    always_comb begin
        case (r4_sector)
            hsv2rgb_pkg::SECTOR_0: begin
                n_out.red = q_full; n_out.green = q_rise; n_out.blue = q_low;
            end
            hsv2rgb_pkg::SECTOR_1: begin
                n_out.red = q_fall; n_out.green = q_full; n_out.blue = q_low;
            end
            hsv2rgb_pkg::SECTOR_2: begin
                n_out.red = q_low; n_out.green = q_full; n_out.blue = q_rise;
            end
            hsv2rgb_pkg::SECTOR_3: begin
                n_out.red = q_low; n_out.green = q_fall; n_out.blue = q_full;
            end
            hsv2rgb_pkg::SECTOR_4: begin
                n_out.red = q_rise; n_out.green = q_low; n_out.blue = q_full;
            end
            default: begin
                n_out.red = q_full; n_out.green = q_low; n_out.blue = q_fall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld[4];
    assign o_word  = r_out;

endmodule
